/* rtl/wcsc_pkg.sv */
// Shared types and constants of the wall column span clipper.
// No dependencies; used by wall_column_span_clipper and wcsc_checker.
package wcsc_pkg;

    localparam int SCREEN_WIDTH_DEF  = 1920;
    localparam int SCREEN_HEIGHT_DEF = 1080;
    localparam int FRAC_BITS_DEF     = 8;

    localparam int COORD_W = 24;
    localparam int COL_W   = 11;
    localparam int ROW_W   = 11;
    localparam int MODE_W  = 2;

    localparam int NUM_REGS  = 6;
    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] REG_CULL_LEFT         = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CULL_RIGHT        = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CULL_TOP_LEFT     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CULL_TOP_RIGHT    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CULL_BOTTOM_LEFT  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_CULL_BOTTOM_RIGHT = 3'd5;

    localparam logic [COORD_W-1:0] RST_CULL_LEFT         = 24'd256;
    localparam logic [COORD_W-1:0] RST_CULL_RIGHT        = 24'd491264;
    localparam logic [COORD_W-1:0] RST_CULL_TOP_LEFT     = 24'd256;
    localparam logic [COORD_W-1:0] RST_CULL_TOP_RIGHT    = 24'd256;
    localparam logic [COORD_W-1:0] RST_CULL_BOTTOM_LEFT  = 24'd276224;
    localparam logic [COORD_W-1:0] RST_CULL_BOTTOM_RIGHT = 24'd276224;

    localparam logic [MODE_W-1:0] MODE_BOTH    = 2'd0;
    localparam logic [MODE_W-1:0] MODE_CEILING = 2'd1;
    localparam logic [MODE_W-1:0] MODE_FLOOR   = 2'd2;
    localparam logic [MODE_W-1:0] MODE_NONE    = 2'd3;

    typedef struct packed {
        logic        [COL_W-1:0]   column;
        logic signed [COORD_W-1:0] left_x;
        logic signed [COORD_W-1:0] right_x;
        logic signed [COORD_W-1:0] top_at_left;
        logic signed [COORD_W-1:0] top_at_right;
        logic signed [COORD_W-1:0] bottom_at_left;
        logic signed [COORD_W-1:0] bottom_at_right;
        logic        [MODE_W-1:0]  buffer_mode;
    } t_in_word;

    typedef struct packed {
        logic [COL_W-1:0] column_out;
        logic             covered;
        logic [ROW_W-1:0] span_top;
        logic [ROW_W-1:0] span_bottom;
        logic             write_ceiling;
        logic             write_floor;
    } t_out_word;

    // fields that ride alongside the dividers
    typedef struct packed {
        logic        [COL_W-1:0]   column;
        logic        [MODE_W-1:0]  mode;
        logic                      covered;
        logic signed [COORD_W-1:0] top_l;
        logic signed [COORD_W-1:0] bot_l;
        logic signed [COORD_W-1:0] ctop_l;
        logic signed [COORD_W-1:0] cbot_l;
    } t_side;

endpackage

/* rtl/wcsc_div.sv */
// Pipelined signed divider, one quotient bit per stage, truncating toward zero.
// No package dependencies; instanced by wall_column_span_clipper.
module wcsc_div #(
    parameter int NW = 48,
    parameter int DW = 24
) (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic signed [NW:0]   i_num,
    input  logic signed [DW:0]   i_den,
    output logic signed [NW:0]   o_quo
);

    logic [NW:0] c_num_abs;
    logic [DW:0] c_den_abs;

    logic [DW-1:0] r_rem [NW];
    logic [NW-1:0] r_num [NW];
    logic [DW-1:0] r_den [NW];
    logic          r_neg [NW];

    assign c_num_abs = i_num[NW] ? $unsigned(-i_num) : $unsigned(i_num);
    assign c_den_abs = i_den[DW] ? $unsigned(-i_den) : $unsigned(i_den);

    for (genvar k = 0; k < NW; k++) begin : g_st
        logic [DW-1:0] a_rem;
        logic [NW-1:0] a_num;
        logic [DW-1:0] a_den;
        logic          a_neg;
        logic [DW:0]   t;
        logic          ge;

        if (k == 0) begin : g_first
            assign a_rem = '0;
            assign a_num = c_num_abs[NW-1:0];
            assign a_den = c_den_abs[DW-1:0];
            assign a_neg = i_num[NW] ^ i_den[DW];
        end else begin : g_next
            assign a_rem = r_rem[k-1];
            assign a_num = r_num[k-1];
            assign a_den = r_den[k-1];
            assign a_neg = r_neg[k-1];
        end

        assign t  = {a_rem, a_num[NW-1]};
        assign ge = t >= {1'b0, a_den};

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k] <= ge ? DW'(t - {1'b0, a_den}) : t[DW-1:0];
                r_num[k] <= {a_num[NW-2:0], ge};
                r_den[k] <= a_den;
                r_neg[k] <= a_neg;
            end
        end
    end

    assign o_quo = r_neg[NW-1] ? -$signed({1'b0, r_num[NW-1]})
                               : $signed({1'b0, r_num[NW-1]});

endmodule

/* rtl/wall_column_span_clipper.sv */
// One column span per clock: S1 differences and x coverage, S2 four multiplies,
// then four bit-serial-pipelined dividers (one quotient bit per stage, about
// 50 stages at 8 fraction bits), then add, row truncate and swap, and the
// clamp into the output register. Throughput one word per cycle; a stall at
// the output freezes the whole pipe. Config regs are written through the cfg
// port, always ready; the user must write them only while the block is idle,
// which the block itself does not enforce. Depends on wcsc_pkg and wcsc_div.
module wall_column_span_clipper #(
    parameter int SCREEN_WIDTH  = wcsc_pkg::SCREEN_WIDTH_DEF,
    parameter int SCREEN_HEIGHT = wcsc_pkg::SCREEN_HEIGHT_DEF,
    parameter int FRAC_BITS     = wcsc_pkg::FRAC_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  wcsc_pkg::t_in_word                  i_word,
    output logic                                o_valid,
    input  logic                                i_stall,
    output wcsc_pkg::t_out_word                 o_word,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [wcsc_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [wcsc_pkg::COORD_W-1:0]        i_cfg_data
);

    localparam int CW    = wcsc_pkg::COORD_W;
    localparam int PSW   = wcsc_pkg::COL_W + 1 + FRAC_BITS;
    localparam int DXW   = ((PSW > CW) ? PSW : CW) + 1;
    localparam int DYW   = CW + 1;
    localparam int PRW   = DXW + DYW;
    localparam int NW    = PRW - 1;
    localparam int SW    = NW + 2;
    localparam int ONE_I = 1 << FRAC_BITS;

    localparam logic signed [DYW-1:0] ONE_D = DYW'(ONE_I);
    localparam logic signed [SW:0]    BIAS  = (SW + 1)'(ONE_I - 1);
    localparam logic signed [SW-1:0]  LO_V  = SW'(1);
    localparam logic signed [SW-1:0]  HI_X  = SW'(SCREEN_WIDTH - 1);
    localparam logic signed [SW-1:0]  HI_Y  = SW'(SCREEN_HEIGHT - 1);

    function automatic logic signed [SW-1:0] f_trunc(input logic signed [SW-1:0] v);
        logic signed [SW:0] b;
        b = (SW + 1)'(v) + (v[SW-1] ? BIAS : (SW + 1)'(0));
        return SW'(b >>> FRAC_BITS);
    endfunction

    function automatic logic signed [SW-1:0] f_clamp(input logic signed [SW-1:0] v,
                                                     input logic signed [SW-1:0] lo,
                                                     input logic signed [SW-1:0] hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    logic [CW-1:0] r_cfg [wcsc_pkg::NUM_REGS];
    logic          en;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg[0] <= wcsc_pkg::RST_CULL_LEFT;
            r_cfg[1] <= wcsc_pkg::RST_CULL_RIGHT;
            r_cfg[2] <= wcsc_pkg::RST_CULL_TOP_LEFT;
            r_cfg[3] <= wcsc_pkg::RST_CULL_TOP_RIGHT;
            r_cfg[4] <= wcsc_pkg::RST_CULL_BOTTOM_LEFT;
            r_cfg[5] <= wcsc_pkg::RST_CULL_BOTTOM_RIGHT;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                wcsc_pkg::REG_CULL_LEFT:         r_cfg[0] <= i_cfg_data;
                wcsc_pkg::REG_CULL_RIGHT:        r_cfg[1] <= i_cfg_data;
                wcsc_pkg::REG_CULL_TOP_LEFT:     r_cfg[2] <= i_cfg_data;
                wcsc_pkg::REG_CULL_TOP_RIGHT:    r_cfg[3] <= i_cfg_data;
                wcsc_pkg::REG_CULL_BOTTOM_LEFT:  r_cfg[4] <= i_cfg_data;
                wcsc_pkg::REG_CULL_BOTTOM_RIGHT: r_cfg[5] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    logic signed [CW-1:0] cl, cr, ctl, ctr, cbl, cbr;
    assign cl  = $signed(r_cfg[0]);
    assign cr  = $signed(r_cfg[1]);
    assign ctl = $signed(r_cfg[2]);
    assign ctr = $signed(r_cfg[3]);
    assign cbl = $signed(r_cfg[4]);
    assign cbr = $signed(r_cfg[5]);

    // S1: differences, widths and coverage
    logic signed [PSW-1:0] c_pos;
    logic signed [DXW-1:0] c_dx_w, c_dx_p;
    logic signed [DYW-1:0] c_dy [4];
    logic signed [DYW-1:0] c_w, c_pwr, c_pw;
    logic signed [SW-1:0]  c_cli, c_cri, c_sx, c_ex, c_col;
    wcsc_pkg::t_side       c_sd;

    assign c_pos  = PSW'($signed({1'b0, i_word.column})) <<< FRAC_BITS;
    assign c_dx_w = DXW'(c_pos) - DXW'(i_word.left_x);
    assign c_dx_p = DXW'(c_pos) - DXW'(cl);
    assign c_dy[0] = DYW'(i_word.top_at_right) - DYW'(i_word.top_at_left);
    assign c_dy[1] = DYW'(i_word.bottom_at_right) - DYW'(i_word.bottom_at_left);
    assign c_dy[2] = DYW'(ctr) - DYW'(ctl);
    assign c_dy[3] = DYW'(cbr) - DYW'(cbl);
    assign c_w   = (i_word.right_x > i_word.left_x)
                 ? DYW'(i_word.right_x) - DYW'(i_word.left_x) : ONE_D;
    assign c_pwr = DYW'(cr) - DYW'(cl);
    assign c_pw  = (c_pwr == '0) ? ONE_D : c_pwr;

    assign c_cli = f_trunc(SW'(cl));
    assign c_cri = f_trunc(SW'(cr));
    assign c_sx  = f_clamp(f_clamp(f_trunc(SW'(i_word.left_x)), c_cli, c_cri), LO_V, HI_X);
    assign c_ex  = f_clamp(f_clamp(f_trunc(SW'(i_word.right_x)), c_cli, c_cri), LO_V, HI_X);
    assign c_col = SW'($signed({1'b0, i_word.column}));

    always_comb begin
        c_sd.column  = i_word.column;
        c_sd.mode    = i_word.buffer_mode;
        c_sd.covered = (c_col >= c_sx) && (c_col < c_ex);
        c_sd.top_l   = i_word.top_at_left;
        c_sd.bot_l   = i_word.bottom_at_left;
        c_sd.ctop_l  = ctl;
        c_sd.cbot_l  = cbl;
    end

    logic                  r1_valid, r2_valid;
    logic signed [DXW-1:0] r1_dx_w, r1_dx_p;
    logic signed [DYW-1:0] r1_dy [4];
    logic signed [DYW-1:0] r1_w, r1_pw, r2_w, r2_pw;
    logic signed [PRW-1:0] r2_prod [4];
    wcsc_pkg::t_side       r1_sd, r2_sd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
        end else if (en) begin
            r1_valid <= i_valid;
            r2_valid <= r1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_dx_w <= c_dx_w;
            r1_dx_p <= c_dx_p;
            r1_dy   <= c_dy;
            r1_w    <= c_w;
            r1_pw   <= c_pw;
            r1_sd   <= c_sd;
            r2_prod[0] <= r1_dx_w * r1_dy[0];
            r2_prod[1] <= r1_dx_w * r1_dy[1];
            r2_prod[2] <= r1_dx_p * r1_dy[2];
            r2_prod[3] <= r1_dx_p * r1_dy[3];
            r2_w    <= r1_w;
            r2_pw   <= r1_pw;
            r2_sd   <= r1_sd;
        end
    end

    // divider stages
    logic signed [NW:0] c_quo [4];

    for (genvar j = 0; j < 4; j++) begin : g_div
        wcsc_div #(.NW(NW), .DW(CW)) u_div (
            .i_clk (i_clk),
            .i_en  (en),
            .i_num (r2_prod[j]),
            .i_den ((j < 2) ? r2_w : r2_pw),
            .o_quo (c_quo[j])
        );
    end

    logic            r_dv [NW];
    wcsc_pkg::t_side r_dsd [NW];

    for (genvar k = 0; k < NW; k++) begin : g_side
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv[k] <= 1'b0;
            end else if (en) begin
                r_dv[k] <= (k == 0) ? r2_valid : r_dv[(k == 0) ? 0 : k - 1];
            end
        end
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_dsd[k] <= (k == 0) ? r2_sd : r_dsd[(k == 0) ? 0 : k - 1];
            end
        end
    end

    // S3 add left value, S4 truncate and order, S5 clamp
    logic                 r3_valid, r4_valid, r5_valid;
    logic signed [SW-1:0] r3_sum [4];
    logic signed [SW-1:0] r4_top, r4_bot, r4_c0, r4_c1;
    logic signed [SW-1:0] c_t, c_b, c_top, c_bot;
    wcsc_pkg::t_side      r3_sd, r4_sd;
    wcsc_pkg::t_out_word  r5_word;

    assign c_t   = f_trunc(r3_sum[0]);
    assign c_b   = f_trunc(r3_sum[1]);
    assign c_top = f_clamp(f_clamp(r4_top, r4_c0, r4_c1), LO_V, HI_Y);
    assign c_bot = f_clamp(f_clamp(r4_bot, r4_c0, r4_c1), LO_V, HI_Y);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_valid <= 1'b0;
            r4_valid <= 1'b0;
            r5_valid <= 1'b0;
        end else if (en) begin
            r3_valid <= r_dv[NW-1];
            r4_valid <= r3_valid;
            r5_valid <= r4_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r3_sum[0] <= SW'(c_quo[0]) + SW'(r_dsd[NW-1].top_l);
            r3_sum[1] <= SW'(c_quo[1]) + SW'(r_dsd[NW-1].bot_l);
            r3_sum[2] <= SW'(c_quo[2]) + SW'(r_dsd[NW-1].ctop_l);
            r3_sum[3] <= SW'(c_quo[3]) + SW'(r_dsd[NW-1].cbot_l);
            r3_sd     <= r_dsd[NW-1];
            r4_top    <= (c_t > c_b) ? c_b : c_t;
            r4_bot    <= (c_t > c_b) ? c_t : c_b;
            r4_c0     <= f_trunc(r3_sum[2]);
            r4_c1     <= f_trunc(r3_sum[3]);
            r4_sd     <= r3_sd;
            r5_word.column_out    <= r4_sd.column;
            r5_word.covered       <= r4_sd.covered;
            r5_word.span_top      <= r4_sd.covered ? wcsc_pkg::ROW_W'(c_top) : '0;
            r5_word.span_bottom   <= r4_sd.covered ? wcsc_pkg::ROW_W'(c_bot) : '0;
            r5_word.write_ceiling <= r4_sd.covered &&
                (r4_sd.mode == wcsc_pkg::MODE_BOTH || r4_sd.mode == wcsc_pkg::MODE_CEILING);
            r5_word.write_floor   <= r4_sd.covered &&
                (r4_sd.mode == wcsc_pkg::MODE_BOTH || r4_sd.mode == wcsc_pkg::MODE_FLOOR);
        end
    end

    assign en      = !(r5_valid && i_stall);
    assign o_stall = !en;
    assign o_valid = r5_valid;
    assign o_word  = r5_word;

endmodule

/* rtl/wcsc_checker.sv */
// Port-level checks on the result channel of the span clipper.
// Depends on wcsc_pkg; bound to wall_column_span_clipper below.
module wcsc_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_valid,
    input logic                i_stall,
    input wcsc_pkg::t_out_word o_word
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_word))
        else $error("stalled word changed");

    a_uncovered: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_word.covered |-> o_word.span_top == '0 &&
            o_word.span_bottom == '0 && !o_word.write_ceiling && !o_word.write_floor)
        else $error("uncovered column carries a span");

    a_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_word.write_ceiling || o_word.write_floor) |-> o_word.covered)
        else $error("write flag without coverage");

    a_rows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_word.covered |-> o_word.span_top != '0 && o_word.span_bottom != '0)
        else $error("covered span hits row zero");

endmodule

bind wall_column_span_clipper wcsc_checker u_wcsc_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .o_valid (o_valid),
    .i_stall (i_stall),
    .o_word  (o_word)
);
